/* hdl/spss_pkg.sv */
// spss_pkg: shared constants, codes and types of the soil probe sample sequencer
// used by spss_pct_div and soil_probe_sample_sequencer; depends on nothing else
package spss_pkg;

  // default field widths
  localparam int unsigned ADC_BITS_DEF   = 10;
  localparam int unsigned TIMER_BITS_DEF = 16;

  // percent field
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned PCT_FULL = 100;

  // register reset values, truncated to the register width where they are used
  localparam int unsigned MIN_LEVEL_RST    = 0;
  localparam int unsigned MAX_LEVEL_RST    = 1023;
  localparam int unsigned SETTLE_RST       = 100;
  localparam int unsigned CHECK_PERIOD_RST = 1000;

  // command codes carried by the input transaction
  localparam int unsigned MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_START = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FORCE = 2'd2;

  // configuration register indexes
  localparam int unsigned REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_MIN_LEVEL    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_LEVEL    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SETTLE       = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_CHECK_PERIOD = 2'd3;

  // status from the percent unit to the sequencer
  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] pct;
  } pct_stat_t;

endpackage

/* hdl/spss_pct_div.sv */
// spss_pct_div: percent scaling of a raw level with a bit-serial restoring divider
// depends on spss_pkg
module spss_pct_div #(
  parameter int unsigned ADC_BITS = spss_pkg::ADC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [ADC_BITS-1:0] raw_level,
  input  logic [ADC_BITS-1:0] min_level,
  input  logic [ADC_BITS-1:0] max_level,
  output spss_pkg::pct_stat_t stat
);
  import spss_pkg::*;

  localparam int unsigned NUM_W = ADC_BITS + PCT_W;
  localparam int unsigned CNT_W = $clog2(PCT_W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SIGN,
    S_MUL,
    S_DIV
  } state_t;

  state_t              state_r;
  logic [ADC_BITS:0]   diff_r;
  logic [ADC_BITS:0]   den_r;
  logic [ADC_BITS-1:0] an_r;
  logic [ADC_BITS-1:0] ad_r;
  logic [ADC_BITS-1:0] rem_r;
  logic [PCT_W-1:0]    quo_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [PCT_W-1:0]    pct_r;
  logic                done_r;

  logic [ADC_BITS:0]   an_w;
  logic [ADC_BITS:0]   ad_w;
  logic                zero_w;
  logic                full_w;
  logic [NUM_W-1:0]    num_w;
  logic [ADC_BITS:0]   rem2_w;
  logic [ADC_BITS:0]   sub_w;
  logic                ge_w;

  always_comb begin
    an_w   = diff_r[ADC_BITS] ? (~diff_r + 1'b1) : diff_r;
    ad_w   = den_r[ADC_BITS] ? (~den_r + 1'b1) : den_r;
    // opposite signs or a zero operand give a quotient of zero or below
    zero_w = (den_r == '0) || (diff_r == '0) || (diff_r[ADC_BITS] != den_r[ADC_BITS]);
    // quotient reaches full scale exactly when |raw-min| >= |max-min|
    full_w = an_w[ADC_BITS-1:0] >= ad_w[ADC_BITS-1:0];
    num_w  = NUM_W'(an_r) * NUM_W'(PCT_FULL);
    rem2_w = {rem_r, quo_r[PCT_W-1]};
    sub_w  = rem2_w - {1'b0, ad_r};
    ge_w   = rem2_w >= {1'b0, ad_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            diff_r  <= {1'b0, raw_level} - {1'b0, min_level};
            den_r   <= {1'b0, max_level} - {1'b0, min_level};
            state_r <= S_SIGN;
          end
        end
        S_SIGN: begin
          if (zero_w) begin
            pct_r   <= '0;
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end else if (full_w) begin
            pct_r   <= PCT_W'(PCT_FULL);
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            an_r    <= an_w[ADC_BITS-1:0];
            ad_r    <= ad_w[ADC_BITS-1:0];
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          // upper part is below the divisor since the quotient is under 2^PCT_W
          rem_r   <= num_w[NUM_W-1:PCT_W];
          quo_r   <= num_w[PCT_W-1:0];
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= ge_w ? sub_w[ADC_BITS-1:0] : rem2_w[ADC_BITS-1:0];
          quo_r <= {quo_r[PCT_W-2:0], ge_w};
          if (cnt_r == CNT_W'(PCT_W - 1)) begin
            pct_r   <= {quo_r[PCT_W-2:0], ge_w};
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign stat.done = done_r;
  assign stat.pct  = pct_r;

endmodule

/* hdl/soil_probe_sample_sequencer.sv */
// soil_probe_sample_sequencer: top level of the tick-driven probe sampler
// depends on spss_pkg and spss_pct_div
//
// Every input transaction is one time tick carrying a command (in_tuser) and the
// current converter value (in_tdata). The sequencer stays stopped until a start
// command; it then powers the probe, counts settle_ticks further ticks, latches
// the converter value, drops power and counts check_period_ticks further ticks
// before the next reading. A force command restarts the reading while running.
// Each tick gives exactly one output transaction with power state, the held raw
// level, a 0..100 percent level, a sample flag and the phase. Each accepted tick
// first updates the phase; the percent unit then checks signs and range, scales
// by one hundred and runs its serial divider at one quotient bit per cycle
// (seven bits). Ticks that fall to zero or full scale skip the scaling and the
// division. The next tick is accepted as soon as the result sits in the output
// register, even if the sink has not taken it yet. Configuration writes are
// always accepted; they are meant to happen between ticks.
module soil_probe_sample_sequencer #(
  parameter int unsigned ADC_BITS   = spss_pkg::ADC_BITS_DEF,
  parameter int unsigned TIMER_BITS = spss_pkg::TIMER_BITS_DEF,
  localparam int unsigned IN_W      = ((ADC_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_F_W   = ADC_BITS + spss_pkg::PCT_W + 4,
  localparam int unsigned OUT_W     = ((OUT_F_W + 7) / 8) * 8,
  localparam int unsigned CFG_W     = (ADC_BITS > TIMER_BITS) ? ADC_BITS : TIMER_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input ticks
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [IN_W-1:0]                   in_tdata,   // adc_sample, zero padded
  input  logic [spss_pkg::MODE_W-1:0]       in_tuser,   // mode
  // results
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // probe_power, raw_level, percent_level, sample_taken, phase, zero padded
  output logic [OUT_W-1:0]                  out_tdata,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [spss_pkg::REG_IDX_W-1:0]    cfg_addr,
  input  logic [CFG_W-1:0]                  cfg_data
);
  import spss_pkg::*;

  localparam int unsigned PAD_W = OUT_W - OUT_F_W;

  // sequencer phase, values as reported on the phase field
  typedef enum logic [1:0] {
    PH_STOPPED  = 2'd0,
    PH_BEGIN    = 2'd1,
    PH_SETTLING = 2'd2,
    PH_IDLE     = 2'd3
  } phase_t;

  // configuration registers
  logic [ADC_BITS-1:0]   min_level_r;
  logic [ADC_BITS-1:0]   max_level_r;
  logic [TIMER_BITS-1:0] settle_r;
  logic [TIMER_BITS-1:0] check_period_r;

  // sequencer state
  phase_t                phase_r;
  phase_t                phase_nxt;
  logic [TIMER_BITS-1:0] tick_cnt_r;
  logic [TIMER_BITS-1:0] tick_cnt_nxt;
  logic [ADC_BITS-1:0]   held_r;
  logic [ADC_BITS-1:0]   held_nxt;
  logic                  taken_r;
  logic                  taken_nxt;

  // transaction bookkeeping
  logic                  busy_r;       // tick accepted, result not yet in output register
  logic                  pct_start_r;  // kicks the percent unit in the cycle after acceptance
  logic                  pct_ready_r;  // percent unit finished for the current tick
  logic [PCT_W-1:0]      pct_hold_r;
  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_data_r;

  logic                  in_fire;
  logic                  cfg_fire;
  logic                  out_load;
  logic [ADC_BITS-1:0]   sample_w;
  logic [PCT_W-1:0]      pct_w;
  pct_stat_t             pct_stat;

  assign in_tready = ~busy_r;
  assign in_fire   = in_tvalid & ~busy_r;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;
  assign sample_w  = in_tdata[ADC_BITS-1:0];

  // result moves to the output register once the percent is known and the slot is free
  assign out_load  = busy_r & (pct_ready_r | pct_stat.done) & (~out_valid_r | out_tready);
  assign pct_w     = pct_stat.done ? pct_stat.pct : pct_hold_r;

  // command first, then one action of the resulting phase
  always_comb begin
    phase_t ph;
    ph           = phase_r;
    tick_cnt_nxt = tick_cnt_r;
    held_nxt     = held_r;
    taken_nxt    = 1'b0;
    if (in_tuser == MODE_START) begin
      ph = PH_BEGIN;
    end else if (in_tuser == MODE_FORCE && phase_r != PH_STOPPED) begin
      ph = PH_BEGIN;
    end
    phase_nxt = ph;
    unique case (ph)
      PH_STOPPED: begin
        phase_nxt = PH_STOPPED;
      end
      PH_BEGIN: begin
        tick_cnt_nxt = settle_r;
        phase_nxt    = PH_SETTLING;
      end
      PH_SETTLING: begin
        if (tick_cnt_r == '0) begin
          held_nxt     = sample_w;
          tick_cnt_nxt = check_period_r;
          phase_nxt    = PH_IDLE;
          taken_nxt    = 1'b1;
        end else begin
          tick_cnt_nxt = tick_cnt_r - 1'b1;
        end
      end
      PH_IDLE: begin
        if (tick_cnt_r == '0) begin
          phase_nxt = PH_BEGIN;
        end else begin
          tick_cnt_nxt = tick_cnt_r - 1'b1;
        end
      end
      default: phase_nxt = PH_STOPPED;
    endcase
  end

  // register writes, values cut to the register widths
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_level_r    <= ADC_BITS'(MIN_LEVEL_RST);
      max_level_r    <= ADC_BITS'(MAX_LEVEL_RST);
      settle_r       <= TIMER_BITS'(SETTLE_RST);
      check_period_r <= TIMER_BITS'(CHECK_PERIOD_RST);
    end else if (cfg_fire) begin
      unique case (cfg_addr)
        REG_MIN_LEVEL:    min_level_r    <= cfg_data[ADC_BITS-1:0];
        REG_MAX_LEVEL:    max_level_r    <= cfg_data[ADC_BITS-1:0];
        REG_SETTLE:       settle_r       <= cfg_data[TIMER_BITS-1:0];
        REG_CHECK_PERIOD: check_period_r <= cfg_data[TIMER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state and transaction control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_STOPPED;
      tick_cnt_r  <= '0;
      held_r      <= '0;
      taken_r     <= 1'b0;
      busy_r      <= 1'b0;
      pct_start_r <= 1'b0;
      pct_ready_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pct_start_r <= in_fire;
      if (in_fire) begin
        phase_r    <= phase_nxt;
        tick_cnt_r <= tick_cnt_nxt;
        held_r     <= held_nxt;
        taken_r    <= taken_nxt;
        busy_r     <= 1'b1;
      end
      if (pct_stat.done) begin
        pct_hold_r <= pct_stat.pct;
      end
      if (out_load) begin
        busy_r      <= 1'b0;
        pct_ready_r <= 1'b0;
        out_valid_r <= 1'b1;
        out_data_r  <= {{PAD_W{1'b0}}, phase_r, taken_r, pct_w, held_r,
                        (phase_r == PH_SETTLING)};
      end else begin
        if (pct_stat.done) begin
          pct_ready_r <= 1'b1;
        end
        if (out_tready) begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  // percent of the held level, computed after every tick
  spss_pct_div #(
    .ADC_BITS (ADC_BITS)
  ) u_pct_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (pct_start_r),
    .raw_level (held_r),
    .min_level (min_level_r),
    .max_level (max_level_r),
    .stat      (pct_stat)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
